/* sv/smsr_pkg.sv */
package smsr_pkg;

	// Shuffle table geometry (depth is a power of two)
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int IDX_SHIFT   = 31 - IDX_W;

	// Generator constants
	localparam logic [30:0] MS_MOD   = 31'h7FFF_FFFF;
	localparam logic [14:0] MS_MULT  = 15'd16807;
	localparam int          WARMUP   = 8;
	localparam int          SEED_STEPS = TABLE_DEPTH + WARMUP;
	localparam int          CNT_W    = $clog2(SEED_STEPS);

	// Controller to datapath commands
	typedef struct packed {
		logic load_seed;
		logic seed_run;
		logic draw_rd;
		logic draw_wr;
	} smsr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic prev_zero;
		logic seed_last;
	} smsr_sts_t;

	// One multiply-mod step: x * 16807 mod (2^31 - 1), Mersenne fold
	function automatic logic [30:0] ms_next(input logic [30:0] x);
		logic [45:0] prod;
		logic [31:0] fold;
		logic [31:0] red;
		prod = 46'(x) * 46'(MS_MULT);
		fold = {1'b0, prod[30:0]} + 32'(prod[45:31]);
		red  = fold - {1'b0, MS_MOD};
		if (fold >= {1'b0, MS_MOD}) begin
			ms_next = red[30:0];
		end else begin
			ms_next = fold[30:0];
		end
	endfunction

endpackage

/* sv/smsr_if.sv */
// Configuration write channel: seed register
interface smsr_cfg_if;
	logic        valid;
	logic        ready;
	logic [30:0] seed;
	modport source (output valid, output seed, input ready);
	modport sink   (input valid, input seed, output ready);
endinterface

// Request channel: one item asks for one draw
interface smsr_req_if;
	logic valid;
	logic ready;
	logic reseed;
	modport source (output valid, output reseed, input ready);
	modport sink   (input valid, input reseed, output ready);
endinterface

// Result channel: one sample per request
interface smsr_rsp_if;
	logic        valid;
	logic        ready;
	logic [30:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

/* sv/smsr_ram.sv */
module smsr_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/smsr_datapath.sv */
module smsr_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [30:0]         cfg_seed,
	input  smsr_pkg::smsr_cmd_t cmd,
	output smsr_pkg::smsr_sts_t sts,
	output logic [30:0]         sample
);
	import smsr_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(SEED_STEPS - 1);
	localparam logic [CNT_W-1:0] CNT_WARMUP = CNT_W'(WARMUP);

	logic [30:0]      seed_q;
	logic [30:0]      gen_q;
	logic [30:0]      prev_q;
	logic [30:0]      sample_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;

	logic [30:0]      gen_nxt;
	logic [30:0]      seed_fix;
	logic [CNT_W-1:0] seed_slot;
	logic [IDX_W-1:0] draw_idx;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [30:0]      ram_wdata;
	logic [30:0]      ram_rdata;

	// Next generator value and start value (zero or modulus taken as one)
	assign gen_nxt  = ms_next(gen_q);
	assign seed_fix = (seed_q == '0 || seed_q == MS_MOD) ? 31'd1 : seed_q;

	// Table slot filled by this seeding step, counted down from the top
	assign seed_slot = CNT_LAST - cnt_q;
	assign draw_idx  = prev_q[30:IDX_SHIFT];

	// Steer the single write port
	assign ram_we    = (cmd.seed_run && cnt_q >= CNT_WARMUP) || cmd.draw_wr;
	assign ram_waddr = cmd.draw_wr ? idx_q : seed_slot[IDX_W-1:0];
	assign ram_wdata = cmd.draw_wr ? gen_q : gen_nxt;

	smsr_ram #(
		.WIDTH (31),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.draw_rd),
		.raddr (draw_idx),
		.rdata (ram_rdata)
	);

	// Seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 31'd1;
		end else if (cfg_we) begin
			seed_q <= cfg_seed;
		end
	end

	// Generator, previous output and seeding counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q  <= '0;
			prev_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.load_seed) begin
				gen_q <= seed_fix;
				cnt_q <= '0;
			end
			if (cmd.seed_run) begin
				gen_q <= gen_nxt;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					prev_q <= gen_nxt;
				end
			end
			if (cmd.draw_rd) begin
				gen_q <= gen_nxt;
			end
			if (cmd.draw_wr) begin
				prev_q <= ram_rdata;
			end
		end
	end

	// Hold the drawn index and the result item
	always_ff @(posedge clk) begin
		if (cmd.draw_rd) begin
			idx_q <= draw_idx;
		end
		if (cmd.draw_wr) begin
			sample_q <= ram_rdata;
		end
	end

	assign sts.prev_zero = (prev_q == '0);
	assign sts.seed_last = (cnt_q == CNT_LAST);
	assign sample        = sample_q;

endmodule

/* sv/smsr_ctrl.sv */
module smsr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                reseed,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output smsr_pkg::smsr_cmd_t cmd,
	input  smsr_pkg::smsr_sts_t sts
);
	import smsr_pkg::*;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SEED    = 2'd1;
	localparam logic [1:0] ST_DRAW_RD = 2'd2;
	localparam logic [1:0] ST_DRAW_WR = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       need_seed;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign need_seed = reseed || sts.prev_zero;
	assign out_free  = !out_valid_q || out_ready;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (need_seed) begin
						cmd.load_seed = 1'b1;
						state_d       = ST_SEED;
					end else begin
						cmd.draw_rd = 1'b1;
						state_d     = ST_DRAW_WR;
					end
				end
			end
			ST_SEED: begin
				cmd.seed_run = 1'b1;
				if (sts.seed_last) begin
					state_d = ST_DRAW_RD;
				end
			end
			ST_DRAW_RD: begin
				cmd.draw_rd = 1'b1;
				state_d     = ST_DRAW_WR;
			end
			ST_DRAW_WR: begin
				if (out_free) begin
					cmd.draw_wr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state, hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.draw_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/shuffled_minimal_standard_rng.sv */
// Channel  Role    Payload               Accepted when
// cfg      sink    seed   [30:0]         cfg.valid && cfg.ready (ready always high)
// req      sink    reseed                req.valid && req.ready
// rsp      source  sample [30:0]         rsp.valid && rsp.ready
//
// A draw reads the table at the accept edge, then writes back and loads the result
// through the single write port of the shuffle table.
// A seeding draw (reseed, or first item after reset) loads the seed, runs the
// 40-step multiply-mod seeding sequence, one step per cycle, then draws as above.
// Reset clears the generator and previous output, so the first item seeds.
// A waiting result holds the block in its write-back step until taken.
module shuffled_minimal_standard_rng (
	input  logic clk,
	input  logic arst_n,
	smsr_cfg_if.sink   cfg,
	smsr_req_if.sink   req,
	smsr_rsp_if.source rsp
);
	import smsr_pkg::*;

	smsr_cmd_t cmd;
	smsr_sts_t sts;

	assign cfg.ready = 1'b1;

	smsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.reseed    (req.reseed),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	smsr_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_seed (cfg.seed),
		.cmd      (cmd),
		.sts      (sts),
		.sample   (rsp.sample)
	);

endmodule

/* bench/shuffled_minimal_standard_rng_test.sv */
module shuffled_minimal_standard_rng_test;
	import smsr_pkg::*;

	localparam int          HALF_PERIOD    = 10;
	localparam int          RESET_CYCLES   = 6;
	localparam int          PHASE_COUNT    = 6;
	localparam int          PHASE_DRAWS    = 305;
	localparam int          LONG_HOLD      = 400;
	localparam int          QUIET_CYCLES   = 50;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int unsigned SLOT_SPAN      = 1 + (int'(MS_MOD) - 1) / TABLE_DEPTH;
	localparam logic [30:0] SEED_ALL_ONES  = 31'h7FFF_FFFF;
	localparam logic [30:0] SEED_MAX       = 31'h7FFF_FFFE;

	// Shadow of the generator: seed register, generator, last output, shuffle table
	class draw_predictor;
		logic [30:0] seed_reg;
		logic [30:0] gen_value;
		logic [30:0] last_sample;
		logic [30:0] shuffle [TABLE_DEPTH];
		logic [30:0] expected_samples [$];
		int          errors;

		function new();
			seed_reg    = 31'd1;
			gen_value   = '0;
			last_sample = '0;
			foreach (shuffle[i]) shuffle[i] = '0;
			errors      = 0;
		endfunction

		function logic [30:0] mult_mod(logic [30:0] x);
			logic [63:0] prod;
			prod = 64'(x) * 64'(MS_MULT);
			return 31'(prod % 64'(MS_MOD));
		endfunction

		function void load_seed(logic [30:0] value);
			seed_reg = value;
		endfunction

		// Run the warm-up chain and fill the table from its last values
		function void refill_table();
			logic [30:0] x;
			x = seed_reg % MS_MOD;
			if (x == 0) x = 31'd1;
			for (int j = SEED_STEPS - 1; j >= 0; j--) begin
				x = mult_mod(x);
				if (j < TABLE_DEPTH) shuffle[j] = x;
			end
			gen_value   = x;
			last_sample = shuffle[0];
		endfunction

		// Predict the sample for one accepted draw request
		function void note_draw(logic reseed);
			int unsigned slot;
			if (reseed || last_sample == 0) refill_table();
			gen_value = mult_mod(gen_value);
			slot = int'(last_sample) / SLOT_SPAN;
			if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
			last_sample   = shuffle[slot];
			shuffle[slot] = gen_value;
			expected_samples = {expected_samples, last_sample};
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_sample(logic [30:0] got);
			logic [30:0] want;
			if (expected_samples.size() == 0) begin
				report($sformatf("sample %0d arrived with no draw pending", got));
			end else begin
				want = expected_samples.pop_front();
				if (got !== want)
					report($sformatf("sample got %0d expected %0d", got, want));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	smsr_cfg_if cfg_ch ();
	smsr_req_if req_ch ();
	smsr_rsp_if rsp_ch ();

	shuffled_minimal_standard_rng uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	draw_predictor predictor = new();

	int  send_steady;
	int  recv_steady;
	int  hold_off_asked;
	int  idle_cycles;

	// Clock
	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	// Mostly short gaps, a few long ones, and now and then a stretch with none
	function automatic int idle_len(inout int steady_left);
		int r;
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			steady_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Track accepted config writes, requests and results
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
				predictor.load_seed(cfg_ch.seed);
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				predictor.note_draw(req_ch.reseed);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				predictor.check_sample(rsp_ch.sample);
		end
	end

	// End the run if no channel moves an item for too long
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
				|| (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				|| (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", idle_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result receiver: random stalls, one long hold-off on request
	initial begin
		int stall;
		int burst;
		int holds_done;
		rsp_ch.ready <= 1'b0;
		recv_steady = 0;
		holds_done  = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_asked > holds_done) begin
				holds_done++;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stall = idle_len(recv_steady);
				if (stall > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			burst = $urandom_range(1, 8);
			repeat (burst) @(posedge clk);
		end
	end

	// Offer one draw request, hold it until accepted, then idle for a while
	task draw(bit reseed);
		int gap;
		req_ch.valid  <= 1'b1;
		req_ch.reseed <= reseed;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		gap = idle_len(send_steady);
		if (gap > 0) begin
			req_ch.valid  <= 1'b0;
			req_ch.reseed <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop the request and wait until every expected sample has come back
	task drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (predictor.expected_samples.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the seed register; call only while the block is idle
	task write_seed(logic [30:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.seed  <= value;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [30:0] phase_seed;
		int          reseed_pct;
		arst_n           <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.seed      <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.reseed    <= 1'b0;
		send_steady      = 0;
		hold_off_asked   = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First draw after reset seeds by itself from the reset seed
		draw(1'b0);
		draw(1'b0);
		draw(1'b0);
		draw(1'b0);
		draw(1'b1);
		drain();

		// Zero seed is taken as one
		write_seed('0);
		draw(1'b1);
		draw(1'b0);
		drain();

		// Seed equal to the modulus folds to zero, then to one
		write_seed(SEED_ALL_ONES);
		draw(1'b1);
		draw(1'b0);
		drain();

		// Largest legal seed
		write_seed(SEED_MAX);
		draw(1'b1);
		draw(1'b0);
		draw(1'b0);
		drain();

		// A new seed has no effect until a reseed; back-to-back reseeds
		write_seed(31'h2AAA_AAAA);
		draw(1'b0);
		draw(1'b1);
		draw(1'b1);
		draw(1'b1);
		drain();

		write_seed(31'h5555_5555);
		draw(1'b1);
		draw(1'b0);
		drain();

		// Random phases, each under its own seed and reseed rate
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				1:       phase_seed = 31'd1;
				3:       phase_seed = SEED_ALL_ONES;
				5:       phase_seed = '0;
				default: phase_seed = 31'($urandom);
			endcase
			write_seed(phase_seed);
			case (phase % 3)
				0:       reseed_pct = 2;
				1:       reseed_pct = 10;
				default: reseed_pct = 30;
			endcase
			send_steady = 0;
			if (phase == 2) hold_off_asked++;
			for (int n = 0; n < PHASE_DRAWS; n++)
				draw($urandom_range(0, 99) < reseed_pct);
			drain();
		end

		repeat (QUIET_CYCLES) @(posedge clk);
		if (predictor.expected_samples.size() != 0)
			predictor.report($sformatf("%0d samples never arrived",
				predictor.expected_samples.size()));
		if (predictor.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* files.f */
sv/smsr_pkg.sv
sv/smsr_if.sv
sv/smsr_ram.sv
sv/smsr_datapath.sv
sv/smsr_ctrl.sv
sv/shuffled_minimal_standard_rng.sv
bench/shuffled_minimal_standard_rng_test.sv
